/* sv/bqfb_pkg.sv */
package bqfb_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_COEF   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Coefficient order inside one section's five-entry group.
  localparam int COEFS_PER_SECTION = 5;
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;
  localparam logic [2:0] PH_LAST = 3'd6;

  // Register byte addresses.
  localparam logic [2:0] ADDR_BAND_COUNT    = 3'd0;
  localparam logic [2:0] ADDR_SECTION_COUNT = 3'd4;

  // Product in Q.53 rounded half up to Q8.40.
  function automatic logic signed [50:0] rnd13(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd4096;
    return s[63:13];
  endfunction

  // Saturate to the signed 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [52:0] x);
    logic signed [52:0] hi;
    logic signed [52:0] lo;
    hi = 53'sh7FFFFFFFFFFF;
    lo = -hi - 53'sd1;
    if (x > hi) return hi[47:0];
    if (x < lo) return lo[47:0];
    return x[47:0];
  endfunction

  // Q8.40 accumulator rounded half up to Q8.23.
  function automatic logic signed [31:0] rnd17(input logic signed [47:0] a);
    logic signed [48:0] s;
    s = 49'(a) + 49'sd65536;
    return s[48:17];
  endfunction

  // Saturate a section output to Q1.23.
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7FFFFF;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

/* sv/biquad_filter_bank.sv */
// Multi-band biquad filter bank, transposed direct form II cascades.
// Input stream: s_tuser holds the request kind (sample, coefficient write,
// clear delay state); s_tdata holds the sample and the coefficient fields.
// A coefficient write or a clear gives no output beat.
// A sample produces one output beat per band in use, band 0 first, with
// m_tlast on the final band.
// Each section runs phases 0 to 6 on the shared 32x32 multiplier (five products
// plus coefficient memory read latency), and each band then passes through an
// emit state that hands its beat to the output register. s_tready is low while
// a sample runs, so no new sample is taken until the beat of the last band has
// been handed to the output register.
// If the receiver stalls, the sequencer waits at the end of a band until the
// output register frees; no beat is dropped.
// Reset sets band_count and section_count to 1 and zeroes all delay state
// at once through per-slot valid bits; coefficients are undefined until
// written. The APB port sets band_count (0x0) and section_count (0x4).
module biquad_filter_bank #(
  parameter int MAX_BANDS    = 32,
  parameter int MAX_SECTIONS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // sample[23:0], coef_band[28:24], coef_section[30:29],
                                // coef_select[33:31], coef_value[65:34], zero pad
  input  logic [1:0]  s_tuser,  // req_type
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // band_index[4:0], band_sample[28:5], zero pad
  output logic        m_tlast,  // last
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bqfb_pkg::*;

  localparam int SLOTS = MAX_BANDS * MAX_SECTIONS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CDEP  = SLOTS * COEFS_PER_SECTION;
  localparam int CW    = $clog2(CDEP);
  localparam int BW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int SCW   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // Input fields.
  logic signed [23:0] in_sample;
  logic [4:0]         in_band;
  logic [1:0]         in_section;
  logic [2:0]         in_select;
  logic signed [31:0] in_value;
  req_t               in_req;

  assign in_sample  = s_tdata[23:0];
  assign in_band    = s_tdata[28:24];
  assign in_section = s_tdata[30:29];
  assign in_select  = s_tdata[33:31];
  assign in_value   = s_tdata[65:34];
  assign in_req     = req_t'(s_tuser);

  // Configuration registers.
  logic [5:0] band_count;
  logic [2:0] section_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count    <= 6'd1;
      section_count <= 3'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_SECTION_COUNT[2]) begin
        section_count <= pwdata[2:0];
      end else begin
        band_count <= pwdata[5:0];
      end
    end
  end

  assign prdata = (paddr[2] == ADDR_SECTION_COUNT[2]) ? {29'd0, section_count}
                                                      : {26'd0, band_count};

  // Counts in use, clamped to the supported range.
  logic [6:0] nb_eff;
  logic [3:0] ns_eff;

  always_comb begin
    if (band_count == 6'd0) begin
      nb_eff = 7'd1;
    end else if (7'(band_count) > 7'(MAX_BANDS)) begin
      nb_eff = 7'(MAX_BANDS);
    end else begin
      nb_eff = 7'(band_count);
    end
    if (section_count == 3'd0) begin
      ns_eff = 4'd1;
    end else if (4'(section_count) > 4'(MAX_SECTIONS)) begin
      ns_eff = 4'(MAX_SECTIONS);
    end else begin
      ns_eff = 4'(section_count);
    end
  end

  // Sequencer state.
  state_t             state;
  state_t             state_next;
  logic [2:0]         phase;
  logic [BW-1:0]      band_cnt;
  logic [SCW-1:0]     sec_cnt;
  logic               band_end;
  logic               sec_end;
  logic               out_free;
  logic               accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign band_end = (7'(band_cnt) == nb_eff - 7'd1);
  assign sec_end  = (4'(sec_cnt) == ns_eff - 4'd1);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_req == REQ_SAMPLE) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (phase == PH_LAST && sec_end) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = band_end ? ST_IDLE : ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory addresses.
  logic [SW-1:0] slot;
  logic [CW-1:0] coef_rd_addr;
  logic [CW-1:0] coef_wr_addr;
  logic          coef_wr;

  assign slot         = SW'(int'(band_cnt) * MAX_SECTIONS + int'(sec_cnt));
  assign coef_rd_addr = CW'(int'(slot) * COEFS_PER_SECTION + int'(phase));
  assign coef_wr_addr = CW'((int'(in_band) * MAX_SECTIONS + int'(in_section))
                            * COEFS_PER_SECTION + int'(in_select));
  assign coef_wr = accept && in_req == REQ_COEF && int'(in_band) < MAX_BANDS
                   && int'(in_section) < MAX_SECTIONS && in_select <= SEL_A2;

  // Coefficient memory.
  logic signed [31:0] coef_mem [CDEP];
  logic signed [31:0] coef_q;

  always_ff @(posedge clk) begin
    if (coef_wr) coef_mem[coef_wr_addr] <= in_value;
    coef_q <= coef_mem[coef_rd_addr];
  end

  // Delay memory, z1 in the upper half and z2 in the lower half.
  logic [95:0]        dly_mem [SLOTS];
  logic [95:0]        dly_q;
  logic               dly_wr;
  logic signed [47:0] z1_new;
  logic signed [47:0] z2_new;
  logic signed [52:0] t1;

  assign dly_wr = (state == ST_RUN) && (phase == PH_LAST);

  // The saturated z1 was parked in t1 at phase 5.
  always_ff @(posedge clk) begin
    if (dly_wr) dly_mem[slot] <= {t1[47:0], z2_new};
    dly_q <= dly_mem[slot];
  end

  // Valid bits stand for the zeroed delay state after reset or a clear.
  logic [SLOTS-1:0] dly_valid;
  logic             dly_valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_valid <= '0;
    end else if (accept && in_req == REQ_CLEAR) begin
      dly_valid <= '0;
    end else if (dly_wr) begin
      dly_valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dly_valid_q <= dly_valid[slot];
  end

  // Shared multiplier with one register after it.
  logic signed [31:0] x_in;
  logic signed [31:0] v;
  logic signed [31:0] y;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [50:0] prod_r;
  logic signed [47:0] z1;
  logic signed [47:0] z2;
  logic signed [52:0] t2;
  logic signed [47:0] acc;

  assign mul_b  = (phase == SEL_A1 + 3'd1 || phase == SEL_A2 + 3'd1) ? y : v;
  assign prod_r = rnd13(prod);
  assign acc    = sat48(53'(prod_r) + 53'(z1));
  assign z1_new = sat48(t1 - 53'(prod_r));
  assign z2_new = sat48(t2 - 53'(prod_r));

  always_ff @(posedge clk) begin
    prod <= coef_q * mul_b;
  end

  // Section datapath, one step per phase.
  always_ff @(posedge clk) begin
    if (accept && in_req == REQ_SAMPLE) begin
      x_in <= 32'(in_sample);
      v    <= 32'(in_sample);
    end else if (state == ST_RUN) begin
      unique case (phase)
        3'd1: begin
          z1 <= dly_valid_q ? dly_q[95:48] : '0;
          z2 <= dly_valid_q ? dly_q[47:0] : '0;
        end
        3'd2: y  <= rnd17(acc);
        3'd3: t1 <= 53'(prod_r) + 53'(z2);
        3'd4: t2 <= 53'(prod_r);
        3'd5: t1 <= 53'(z1_new);
        3'd6: v  <= y;
        default: ;
      endcase
    end else if (state == ST_EMIT && out_free) begin
      v <= x_in;
    end
  end

  // Phase, section and band counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      sec_cnt  <= '0;
      band_cnt <= '0;
    end else if (accept && in_req == REQ_SAMPLE) begin
      phase    <= '0;
      sec_cnt  <= '0;
      band_cnt <= '0;
    end else if (state == ST_RUN) begin
      if (phase == PH_LAST) begin
        phase   <= '0;
        sec_cnt <= sec_end ? '0 : sec_cnt + 1'b1;
      end else begin
        phase <= phase + 3'd1;
      end
    end else if (state == ST_EMIT && out_free && !band_end) begin
      band_cnt <= band_cnt + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {3'd0, sat24(v), 5'(band_cnt)};
      m_tlast <= band_end;
    end
  end

  // The input side is closed while a sample is in flight.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("input open while busy");

  // The phase counter stays within one section's steps.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_LAST) else $error("phase out of range");

  // A delay write lands only right after a section's a2 product.
  a_dly_wr: assert property (@(posedge clk) disable iff (rst)
    dly_wr |-> $past(state == ST_RUN && phase == 3'd5)) else $error("stray delay write");

  // The final beat of a sample carries the last band in use.
  a_last_band: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[4:0] == 5'(nb_eff - 7'd1)))
    else $error("last beat on wrong band");

endmodule
